// ----- sv/utf8d_pkg.sv -----
// Shared types and constants of the UTF-8 to UTF-16LE decoder.
package utf8d_pkg;

    // Front sequencer state: waiting for a lead, collecting trailing bytes, or skipping
    typedef enum logic [2:0] {
        FS_LEAD,
        FS_NEED1,
        FS_NEED2,
        FS_RAW4,
        FS_STOPPED
    } fsm_t;

    // One queued operation: one result, or two for the raw four-byte passthrough
    typedef struct packed {
        logic [15:0] unit_a;
        logic [15:0] unit_b;
        logic        two;
        logic        unit_valid;
        logic        is_last;
    } op_t;

    localparam logic [7:0]  ASCII_LIMIT = 8'h80;
    localparam logic [7:0]  MASK_LEAD3  = 8'he0;
    localparam logic [7:0]  MASK_LEAD2  = 8'hc0;
    localparam logic [7:0]  MASK_HI4    = 8'h0f;
    localparam logic [7:0]  MASK_LO6    = 8'h3f;
    localparam logic [7:0]  MASK_LO5    = 8'h1f;
    localparam logic [7:0]  RAW_LEAD    = 8'he9;
    localparam logic [7:0]  RAW_SECOND  = 8'hfe;
    localparam logic [15:0] RAW_UNIT    = 16'hfee9;

    // Register index of the configuration port
    localparam logic REG_STOP_AT_NUL = 1'b0;

endpackage

// ----- sv/utf8d_front.sv -----
// Front end: accepts source bytes, tracks multi-byte sequences, builds queue operations.
module utf8d_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             accept,
    input  logic [7:0]       in_byte,
    input  logic             in_last,
    input  logic             stop_at_nul,
    output logic             push,
    output utf8d_pkg::op_t   push_op
);

    utf8d_pkg::fsm_t state_reg, state_next;
    logic [7:0] lead_reg;
    logic [7:0] b1_reg;
    logic [7:0] b2_reg;

    logic lead_is_three;
    logic is_nul_stop;
    logic is_lead;

    assign lead_is_three = (lead_reg & utf8d_pkg::MASK_LEAD3) == utf8d_pkg::MASK_LEAD3;
    assign is_nul_stop   = stop_at_nul && (in_byte == 8'h00);
    assign is_lead       = (in_byte & utf8d_pkg::MASK_LEAD2) == utf8d_pkg::MASK_LEAD2;

    always_comb begin
        state_next = state_reg;
        if (accept) begin
            case (state_reg)
                utf8d_pkg::FS_STOPPED: begin
                    if (in_last) state_next = utf8d_pkg::FS_LEAD;
                end
                utf8d_pkg::FS_LEAD: begin
                    if (is_nul_stop) begin
                        if (!in_last) state_next = utf8d_pkg::FS_STOPPED;
                    end else if (in_byte >= utf8d_pkg::ASCII_LIMIT && is_lead && !in_last) begin
                        state_next = utf8d_pkg::FS_NEED1;
                    end
                end
                utf8d_pkg::FS_NEED1: begin
                    if (lead_is_three && !in_last) state_next = utf8d_pkg::FS_NEED2;
                    else                           state_next = utf8d_pkg::FS_LEAD;
                end
                utf8d_pkg::FS_NEED2: begin
                    if (lead_reg == utf8d_pkg::RAW_LEAD && b1_reg == utf8d_pkg::RAW_SECOND
                        && !in_last) begin
                        state_next = utf8d_pkg::FS_RAW4;
                    end else begin
                        state_next = utf8d_pkg::FS_LEAD;
                    end
                end
                utf8d_pkg::FS_RAW4: state_next = utf8d_pkg::FS_LEAD;
                default:            state_next = utf8d_pkg::FS_LEAD;
            endcase
        end
    end

    always_comb begin
        push            = 1'b0;
        push_op.unit_a  = '0;
        push_op.unit_b  = '0;
        push_op.two     = 1'b0;
        push_op.unit_valid = 1'b0;
        push_op.is_last = in_last;
        if (accept) begin
            case (state_reg)
                utf8d_pkg::FS_STOPPED: begin
                    push = in_last;
                end
                utf8d_pkg::FS_LEAD: begin
                    if (is_nul_stop) begin
                        push = in_last;
                    end else if (in_byte < utf8d_pkg::ASCII_LIMIT) begin
                        push               = 1'b1;
                        push_op.unit_a     = {8'h00, in_byte};
                        push_op.unit_valid = 1'b1;
                    end else begin
                        // lead cut off by the end, or stray continuation byte
                        push = in_last;
                    end
                end
                utf8d_pkg::FS_NEED1: begin
                    if (!lead_is_three) begin
                        push               = 1'b1;
                        push_op.unit_a     = {5'b0, lead_reg[4:0], in_byte[5:0]};
                        push_op.unit_valid = 1'b1;
                    end else begin
                        push = in_last;
                    end
                end
                utf8d_pkg::FS_NEED2: begin
                    if (state_next != utf8d_pkg::FS_RAW4) begin
                        push               = 1'b1;
                        push_op.unit_a     = {lead_reg[3:0], b1_reg[5:0], in_byte[5:0]};
                        push_op.unit_valid = 1'b1;
                    end
                end
                utf8d_pkg::FS_RAW4: begin
                    push               = 1'b1;
                    push_op.unit_a     = utf8d_pkg::RAW_UNIT;
                    push_op.unit_b     = {in_byte, b2_reg};
                    push_op.two        = 1'b1;
                    push_op.unit_valid = 1'b1;
                end
                default: push = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= utf8d_pkg::FS_LEAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // Hold the bytes of an unfinished sequence
    always_ff @(posedge aclk) begin
        if (accept) begin
            if (state_reg == utf8d_pkg::FS_LEAD)  lead_reg <= in_byte;
            if (state_reg == utf8d_pkg::FS_NEED1) b1_reg   <= in_byte;
            if (state_reg == utf8d_pkg::FS_NEED2) b2_reg   <= in_byte;
        end
    end

    a_stop_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_last && state_reg == utf8d_pkg::FS_STOPPED) |-> push && push_op.is_last)
        else $error("stopped string did not end with a marker");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && in_last) |=> state_reg == utf8d_pkg::FS_LEAD)
        else $error("state not cleared after last byte");

endmodule

// ----- sv/utf8d_fifo.sv -----
// Short operation queue between the front end and the back end.
module utf8d_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  utf8d_pkg::op_t   push_op,
    input  logic             pop,
    output utf8d_pkg::op_t   head,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    utf8d_pkg::op_t   slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty = count_reg == '0;
    assign full  = count_reg == CNT_W'(DEPTH);
    assign head  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)      count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= push_op;
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (!full || pop))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty)
        else $error("queue underflow");

endmodule

// ----- sv/utf8d_back.sv -----
// Back end: expands queued operations into result beats through an output register.
module utf8d_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  utf8d_pkg::op_t   head,
    input  logic             empty,
    output logic             pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata,
    output logic             m_tuser,
    output logic             m_tlast
);

    logic        m_valid_reg;
    logic [15:0] unit_reg;
    logic        uvalid_reg;
    logic        last_reg;
    logic        phase_reg;   // 1 = first unit of a raw pair already sent

    logic        load;
    logic        emit;
    logic [15:0] beat_unit;
    logic        beat_uvalid;
    logic        beat_last;

    assign load = !m_valid_reg || m_tready;
    assign emit = load && !empty;
    assign pop  = emit && (!head.two || phase_reg);

    always_comb begin
        if (head.two && !phase_reg) begin
            beat_unit   = head.unit_a;
            beat_uvalid = 1'b1;
            beat_last   = 1'b0;
        end else if (head.two) begin
            beat_unit   = head.unit_b;
            beat_uvalid = 1'b1;
            beat_last   = head.is_last;
        end else begin
            beat_unit   = head.unit_a;
            beat_uvalid = head.unit_valid;
            beat_last   = head.is_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            phase_reg   <= 1'b0;
        end else begin
            if (load) m_valid_reg <= emit;
            if (emit) phase_reg   <= head.two && !phase_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            unit_reg   <= beat_unit;
            uvalid_reg <= beat_uvalid;
            last_reg   <= beat_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = unit_reg;
    assign m_tuser  = uvalid_reg;
    assign m_tlast  = last_reg;

    a_pair_held: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg |-> !empty && head.two)
        else $error("second unit of raw pair lost its queue entry");

    a_marker_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> m_tlast && m_tdata == 16'h0000)
        else $error("end marker without last flag");

endmodule

// ----- sv/utf8_to_utf16le_decoder_unit.sv -----
// Top level of the UTF-8 to UTF-16LE decoder: channels, configuration register, queue.
//
// Usage:
//   Source bytes enter on the s_ stream, one byte per beat, s_tlast on the
//   final byte of a string. Decoded 16-bit units leave on the m_ stream;
//   m_tuser = 1 marks a beat carrying a unit, 0 an end-only marker. Every
//   string ends with exactly one beat that has m_tlast set.
//   The decoder takes one byte per cycle while the queue is not full. A byte
//   that completes a unit reaches m_ through a queue entry, then the output
//   register. The raw E9 FE passthrough gives two beats for four bytes.
//   Results drain at one beat per cycle while the receiver is ready; the
//   operation queue of FIFO_DEPTH entries absorbs stalls, and s_tready drops
//   only when it is full, so a stalled receiver backs up into the source
//   once the output register and all FIFO_DEPTH queue entries hold results.
//   stop_at_nul lies at APB byte address 0 (bit 0) and resets to 1; the user
//   must write it only while no string is in flight; the block never checks.
//   Reset clears the sequence state, empties the queue and the output.
module utf8_to_utf16le_decoder_unit #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    // bits: [7:0] in_byte
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        s_tvalid,
    output logic        s_tready,
    // bits: [15:0] code_unit
    output logic [15:0] m_tdata,
    // bits: [0] unit_valid
    output logic        m_tuser,
    output logic        m_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic           stop_reg;
    logic           accept;
    logic           push;
    logic           pop;
    logic           empty;
    logic           full;
    utf8d_pkg::op_t push_op;
    utf8d_pkg::op_t head;

    assign pready   = 1'b1;
    assign s_tready = !full;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stop_reg <= 1'b1;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == utf8d_pkg::REG_STOP_AT_NUL) begin
            stop_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == utf8d_pkg::REG_STOP_AT_NUL) ? {31'b0, stop_reg} : 32'b0;

    utf8d_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .in_byte     (s_tdata),
        .in_last     (s_tlast),
        .stop_at_nul (stop_reg),
        .push        (push),
        .push_op     (push_op)
    );

    utf8d_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head    (head),
        .empty   (empty),
        .full    (full)
    );

    utf8d_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
